>>> sv/smacc_pkg.sv
// shared types, constants and the cordic angle table for the tilt-angle block
// no dependencies; every other file but the checker imports this package
package smacc_pkg;

  localparam int WINDOW       = 60;
  localparam int POS_W        = 6;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 22;
  localparam int OP_W         = 23;
  localparam int MAG_W        = 31;
  localparam int ANG_W        = 34;
  localparam int PROD_W       = 51;
  localparam int STEP_W       = 5;
  localparam int CORDIC_STEPS = 31;
  localparam int ROOT_STEPS   = 22;
  localparam int RAD_W        = 45;
  localparam int DPROD_W      = SUM_W + 16;
  localparam int RECIP        = 34953;
  localparam int RECIP_SHIFT  = 21;
  localparam int ANGLE_W      = 16;
  localparam int PITCH_W      = 15;
  localparam int CLAMP_CD     = 18000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] z;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] x;
  } sums_t;

  typedef struct packed {
    logic                   start;
    logic signed [OP_W-1:0] n;
    logic signed [OP_W-1:0] d;
  } atan_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] angle;
  } atan_rsp_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/smacc_front.sv
// front part: accepts samples, keeps the sample rings and the running sums
// depends on smacc_pkg; pushes updated sums into the queue
module smacc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [47:0]             s_axis_tdata,   // accel_x, accel_y, accel_z
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output smacc_pkg::sums_t        q_data_o
);
  import smacc_pkg::*;

  logic [3*SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]     valid_q;
  logic [POS_W-1:0]      pos_q, wr_addr_q;
  logic                  stg_q;
  logic [3*SAMPLE_W-1:0] rd_data_q;
  logic                  rd_vld_q;
  sample_t               samp_q, old_s;
  sums_t                 sums_q, sums_d;
  logic                  accept;

  assign s_axis_tready = !stg_q && !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    old_s = rd_vld_q ? sample_t'(rd_data_q) : '0;
    sums_d.x = sums_q.x + SUM_W'(samp_q.x) - SUM_W'(old_s.x);
    sums_d.y = sums_q.y + SUM_W'(samp_q.y) - SUM_W'(old_s.y);
    sums_d.z = sums_q.z + SUM_W'(samp_q.z) - SUM_W'(old_s.z);
  end

  assign q_push_o = stg_q;
  assign q_data_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= '0;
      stg_q   <= 1'b0;
      sums_q  <= '0;
    end else begin
      stg_q <= accept;
      if (accept) begin
        pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
      if (stg_q) begin
        sums_q             <= sums_d;
        valid_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= ring_mem[pos_q];
      rd_vld_q  <= valid_q[pos_q];
      samp_q    <= sample_t'(s_axis_tdata);
      wr_addr_q <= pos_q;
    end
    if (stg_q) begin
      ring_mem[wr_addr_q] <= samp_q;
    end
  end

endmodule

>>> sv/smacc_fifo.sv
// two-entry queue of running sums between the front and back parts
// depends on smacc_pkg
module smacc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  smacc_pkg::sums_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output smacc_pkg::sums_t data_o
);
  import smacc_pkg::*;

  sums_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> sv/smacc_atan2.sv
// iterative atan2 unit: normalize, 31 cordic vectoring steps, scale to centidegrees
// depends on smacc_pkg for the angle table and request/response types
module smacc_atan2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smacc_pkg::atan_req_t req_i,
  output smacc_pkg::atan_rsp_t rsp_o
);
  import smacc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_ROT   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic signed [16:0] SCALE_K = 17'sd36000;
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'd1 << 30);

  logic [2:0]               state_q;
  logic                     done_q;
  logic [MAG_W-1:0]         mn_q, md_q, mx;
  logic                     neg_n_q, neg_d_q;
  logic signed [ANG_W-1:0]  x_q, y_q, ang_q, dx, dy, tab;
  logic [STEP_W-1:0]        i_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0]        pmag, rnd;
  logic [18:0]              r;
  logic [14:0]              rc;
  logic signed [ANGLE_W-1:0] angle_q;
  logic [OP_W-1:0]          an, ad;
  logic                     y_pos;

  assign an    = req_i.n[OP_W-1] ? OP_W'(-req_i.n) : req_i.n;
  assign ad    = req_i.d[OP_W-1] ? OP_W'(-req_i.d) : req_i.d;
  assign mx    = (mn_q > md_q) ? mn_q : md_q;
  assign dx    = y_q >>> i_q;
  assign dy    = x_q >>> i_q;
  assign tab   = ANG_W'(atan_entry(i_q));
  assign y_pos = !y_q[ANG_W-1] && (y_q != '0);
  assign pmag  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : prod_q;
  assign rnd   = pmag + (PROD_W'(1) << 31);
  assign r     = rnd[PROD_W-1:32];
  assign rc    = (r > 19'(CLAMP_CD)) ? 15'(CLAMP_CD) : r[14:0];

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            if (req_i.n == '0 && req_i.d == '0) done_q <= 1'b1;
            else state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (mx >= (MAG_W'(1) << 29)) state_q <= S_ROT;
        end
        S_ROT: begin
          if (i_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= S_SCALE;
        end
        S_SCALE: state_q <= S_ROUND;
        S_ROUND: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mn_q    <= MAG_W'(an);
        md_q    <= MAG_W'(ad);
        neg_n_q <= req_i.n[OP_W-1];
        neg_d_q <= req_i.d[OP_W-1];
        if (req_i.start) angle_q <= '0;
      end
      S_NORM: begin
        i_q <= '0;
        if (mx < (MAG_W'(1) << 25)) begin
          mn_q <= mn_q << 4;
          md_q <= md_q << 4;
        end else if (mx < (MAG_W'(1) << 29)) begin
          mn_q <= mn_q << 1;
          md_q <= md_q << 1;
        end else if (!neg_d_q) begin
          x_q   <= ANG_W'(md_q);
          y_q   <= neg_n_q ? -ANG_W'(md_q - md_q + mn_q) : ANG_W'(mn_q);
          ang_q <= '0;
        end else begin
          x_q   <= ANG_W'(mn_q);
          y_q   <= neg_n_q ? -ANG_W'(md_q) : ANG_W'(md_q);
          ang_q <= neg_n_q ? -QUARTER : QUARTER;
        end
      end
      S_ROT: begin
        i_q <= i_q + 1'b1;
        if (y_pos) begin
          x_q   <= x_q + dx;
          y_q   <= y_q - dy;
          ang_q <= ang_q + tab;
        end else begin
          x_q   <= x_q - dx;
          y_q   <= y_q + dy;
          ang_q <= ang_q - tab;
        end
      end
      S_SCALE: prod_q <= ang_q * SCALE_K;
      S_ROUND: angle_q <= prod_q[PROD_W-1] ? -ANGLE_W'(rc) : ANGLE_W'(rc);
      default: ;
    endcase
  end

endmodule

>>> sv/smacc_back.sv
// back part: averages, hypot by bit-serial square root, roll and pitch angles
// depends on smacc_pkg and smacc_atan2; drives the output register
module smacc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  smacc_pkg::sums_t q_data_i,
  output logic             q_pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [79:0]      m_axis_tdata    // avg_x, avg_y, avg_z, roll, pitch, zero pad
);
  import smacc_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_ADD  = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_PST  = 3'd4;
  localparam logic [2:0] B_ANG  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]                  state_q;
  sums_t                       sums_q;
  logic [SUM_W-1:0]            mag [3];
  logic [DPROD_W-1:0]          dprod_q [3];
  logic signed [SAMPLE_W-1:0]  avg_q [3];
  logic [RAD_W-1:0]            sqy_q, sqz_q, v_q, r_q, bit_q, t;
  logic [STEP_W-1:0]           cnt_q;
  logic                        roll_done_q, pitch_done_q;
  atan_req_t                   roll_req, pitch_req;
  atan_rsp_t                   roll_rsp, pitch_rsp;
  logic [79:0]                 data_q;
  logic                        vld_q;
  logic signed [SUM_W-1:0]     s [3];

  assign s[0] = sums_q.x;
  assign s[1] = sums_q.y;
  assign s[2] = sums_q.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = s[k][SUM_W-1] ? SUM_W'(-s[k]) : s[k];
    end
  end

  assign t = r_q + bit_q;

  assign roll_req.start  = (state_q == B_MUL);
  assign roll_req.n      = OP_W'(sums_q.y);
  assign roll_req.d      = OP_W'(sums_q.z);
  assign pitch_req.start = (state_q == B_PST);
  assign pitch_req.n     = -OP_W'(sums_q.x);
  assign pitch_req.d     = OP_W'(r_q);

  smacc_atan2 u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (roll_req),
    .rsp_o  (roll_rsp)
  );

  smacc_atan2 u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pitch_req),
    .rsp_o  (pitch_rsp)
  );

  assign q_pop_o       = (state_q == B_IDLE) && !q_empty_i;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      vld_q        <= 1'b0;
      roll_done_q  <= 1'b0;
      pitch_done_q <= 1'b0;
    end else begin
      if (vld_q && m_axis_tready) vld_q <= 1'b0;
      if (roll_rsp.done) roll_done_q <= 1'b1;
      if (pitch_rsp.done) pitch_done_q <= 1'b1;
      case (state_q)
        B_IDLE: begin
          roll_done_q  <= 1'b0;
          pitch_done_q <= 1'b0;
          if (!q_empty_i) state_q <= B_MUL;
        end
        B_MUL:  state_q <= B_ADD;
        B_ADD:  state_q <= B_ROOT;
        B_ROOT: begin
          if (cnt_q == STEP_W'(ROOT_STEPS - 1)) state_q <= B_PST;
        end
        B_PST:  state_q <= B_ANG;
        B_ANG: begin
          if (roll_done_q && pitch_done_q) state_q <= B_OUT;
        end
        B_OUT: begin
          if (!vld_q || m_axis_tready) begin
            vld_q   <= 1'b1;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic [16:0] q0;
    logic [22:0] q60;
    logic [16:0] q;
    case (state_q)
      B_IDLE: sums_q <= q_data_i;
      B_MUL: begin
        sqy_q <= RAD_W'(mag[1]) * RAD_W'(mag[1]);
        sqz_q <= RAD_W'(mag[2]) * RAD_W'(mag[2]);
        for (int k = 0; k < 3; k++) begin
          dprod_q[k] <= DPROD_W'(mag[k]) * DPROD_W'(RECIP);
        end
      end
      B_ADD: begin
        v_q   <= sqy_q + sqz_q;
        r_q   <= '0;
        bit_q <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
        cnt_q <= '0;
        for (int k = 0; k < 3; k++) begin
          q0  = dprod_q[k][RECIP_SHIFT+16:RECIP_SHIFT];
          q60 = (23'(q0) << 6) - (23'(q0) << 2);
          q   = (q60 > 23'(mag[k])) ? q0 - 1'b1 : q0;
          avg_q[k] <= s[k][SUM_W-1] ? -SAMPLE_W'(q) : SAMPLE_W'(q);
        end
      end
      B_ROOT: begin
        cnt_q <= cnt_q + 1'b1;
        bit_q <= bit_q >> 2;
        if (v_q >= t) begin
          v_q <= v_q - t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
      end
      B_OUT: begin
        if (!vld_q || m_axis_tready) begin
          data_q <= {1'b0, pitch_rsp.angle[PITCH_W-1:0], roll_rsp.angle,
                     avg_q[2], avg_q[1], avg_q[0]};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/smoothed_accel_tilt_angles.sv
// top level of the smoothed accelerometer tilt-angle block
// depends on smacc_pkg, smacc_front, smacc_fifo, smacc_back
//
// Each accepted sample updates 60-deep moving-average rings per axis and
// yields one result: the three averages (sum/60 truncated toward zero),
// roll = atan2(y,z) and pitch = atan2(-x, hypot(y,z)) in hundredths of a
// degree, computed from the sums. The front takes no new sample while the
// last one is still going into the sums or the two-entry queue is full; the
// back takes one sample at a time, its time set by the 22-step square root
// followed by the pitch cordic (normalize, 31 rotation steps, scale and
// round), plus any stall on the output. Rings start cleared.
module smoothed_accel_tilt_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // avg_x, avg_y, avg_z, roll, pitch, zero pad
);
  import smacc_pkg::*;

  sums_t push_data, pop_data;
  logic  push, pop, full, empty;

  smacc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (full),
    .q_push_o      (push),
    .q_data_o      (push_data)
  );

  smacc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  smacc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_data_i      (pop_data),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> sv/smacc_chk.sv
// port-level checker for the tilt-angle block, bound to the top level
// depends on nothing but the top level's ports
module smacc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[79] == 1'b0)
    else $error("pad bit set");

  a_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd18000 &&
                       $signed(m_axis_tdata[63:48]) >= -16'sd18000))
    else $error("roll out of range");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[78:64]) <= 15'sd9000 &&
                       $signed(m_axis_tdata[78:64]) >= -15'sd9000))
    else $error("pitch out of range");

endmodule

bind smoothed_accel_tilt_angles smacc_chk u_chk (.*);
